>>> hw/rtl/dxt5_pkg.sv
// Package: request, response and palette types plus divider reciprocals for the DXT5 decoder.
`timescale 1ns / 1ps

package dxt5_pkg;

   // Request: one 16-byte block as two little-endian 64-bit halves
   typedef struct packed {
      logic [63:0] alpha_half;
      logic [63:0] color_half;
   } req_type;

   // Response: one decoded texel
   typedef struct packed {
      logic [3:0] texel_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha_value;
      logic       last;
   } rsp_type;

   // Per-block palette handed from the table pipeline to the texel emitter
   typedef struct packed {
      logic [7:0][7:0]      alpha_tab;
      logic [3:0][2:0][7:0] color_tab;   // [entry][channel r,g,b]
      logic [47:0]          alpha_idx;
      logic [31:0]          color_idx;
   } pal_type;

   localparam int TEXELS = 16;
   localparam logic [3:0] TEXEL_LAST = 4'd15;

   // Truncating division by reciprocal: q = (n * RECIP) >> RECIP_SHIFT
   // exact for n below 2^14 / 3 with these constants
   localparam int RECIP_SHIFT = 14;
   localparam logic [12:0] RECIP_7 = 13'd2341;
   localparam logic [12:0] RECIP_5 = 13'd3277;
   localparam logic [12:0] RECIP_3 = 13'd5462;

   localparam logic [7:0] ALPHA_ZERO = 8'h00;
   localparam logic [7:0] ALPHA_FULL = 8'hFF;

endpackage

>>> hw/rtl/dxt5_palette.sv
// Two-stage pipeline that builds the alpha and color palettes of one block.
`timescale 1ns / 1ps

module dxt5_palette
   import dxt5_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    expand_replicate,
   input  logic    in_valid,
   input  req_type in_req,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output pal_type out_pal
);

   // Expand 5- and 6-bit channels to 8 bits
   function automatic logic [7:0] widen5(input logic [4:0] v, input logic rep);
      widen5 = {v, rep ? v[4:2] : 3'b000};
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] v, input logic rep);
      widen6 = {v, rep ? v[5:4] : 2'b00};
   endfunction

   // Stage A: endpoints, expanded colors and weighted numerators
   logic                  a_valid_ff;
   logic                  a_mode7_ff, a_mode7_in;
   logic [7:0]            a_a0_ff, a_a1_ff;
   logic [5:0][10:0]      a_num_ff, a_num_in;
   logic [2:0][7:0]       a_e0_ff, a_e0_in, a_e1_ff, a_e1_in;
   logic [2:0][9:0]       a_cn2_ff, a_cn2_in, a_cn3_ff, a_cn3_in;
   logic [47:0]           a_aidx_ff;
   logic [31:0]           a_cidx_ff;

   // Stage B: finished palette
   logic                  b_valid_ff;
   pal_type               b_pal_ff, b_pal_in;

   logic                  a_en, b_en;
   logic [7:0]            a0, a1;
   logic [2:0]            w0, w1;

   assign b_en     = !b_valid_ff || out_ready;
   assign a_en     = !a_valid_ff || b_en;
   assign in_ready = a_en;

   assign a0 = in_req.alpha_half[7:0];
   assign a1 = in_req.alpha_half[15:8];

   // Weighted sums for the interpolated alpha entries and color thirds
   always_comb begin
      a_mode7_in = a0 > a1;
      w0 = '0;
      w1 = '0;
      for (int s = 0; s < 6; s++) begin
         w1 = 3'(s + 1);
         if (a_mode7_in) begin
            w0 = 3'(6 - s);
         end else begin
            w0 = (s < 4) ? 3'(4 - s) : 3'd0;
         end
         a_num_in[s] = 11'(w0) * 11'(a0) + 11'(w1) * 11'(a1);
      end
      a_e0_in[0] = widen5(in_req.color_half[15:11], expand_replicate);
      a_e0_in[1] = widen6(in_req.color_half[10:5], expand_replicate);
      a_e0_in[2] = widen5(in_req.color_half[4:0], expand_replicate);
      a_e1_in[0] = widen5(in_req.color_half[31:27], expand_replicate);
      a_e1_in[1] = widen6(in_req.color_half[26:21], expand_replicate);
      a_e1_in[2] = widen5(in_req.color_half[20:16], expand_replicate);
      for (int c = 0; c < 3; c++) begin
         a_cn2_in[c] = {1'b0, a_e0_in[c], 1'b0} + 10'(a_e1_in[c]);
         a_cn3_in[c] = 10'(a_e0_in[c]) + {1'b0, a_e1_in[c], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_en) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_mode7_ff <= a_mode7_in;
         a_a0_ff    <= a0;
         a_a1_ff    <= a1;
         a_num_ff   <= a_num_in;
         a_e0_ff    <= a_e0_in;
         a_e1_ff    <= a_e1_in;
         a_cn2_ff   <= a_cn2_in;
         a_cn3_ff   <= a_cn3_in;
         a_aidx_ff  <= in_req.alpha_half[63:16];
         a_cidx_ff  <= in_req.color_half[63:32];
      end
   end

   // Reciprocal multiplies finish the divisions by 7, 5 and 3
   always_comb begin
      logic [23:0] prod;
      logic [12:0] recip;
      prod  = '0;
      recip = '0;
      b_pal_in.alpha_tab[0] = a_a0_ff;
      b_pal_in.alpha_tab[1] = a_a1_ff;
      recip = a_mode7_ff ? RECIP_7 : RECIP_5;
      for (int s = 0; s < 6; s++) begin
         prod = 24'(a_num_ff[s]) * 24'(recip);
         b_pal_in.alpha_tab[s + 2] = prod[RECIP_SHIFT + 7:RECIP_SHIFT];
      end
      if (!a_mode7_ff) begin
         b_pal_in.alpha_tab[6] = ALPHA_ZERO;
         b_pal_in.alpha_tab[7] = ALPHA_FULL;
      end
      for (int c = 0; c < 3; c++) begin
         b_pal_in.color_tab[0][c] = a_e0_ff[c];
         b_pal_in.color_tab[1][c] = a_e1_ff[c];
         prod = 24'(a_cn2_ff[c]) * 24'(RECIP_3);
         b_pal_in.color_tab[2][c] = prod[RECIP_SHIFT + 7:RECIP_SHIFT];
         prod = 24'(a_cn3_ff[c]) * 24'(RECIP_3);
         b_pal_in.color_tab[3][c] = prod[RECIP_SHIFT + 7:RECIP_SHIFT];
      end
      b_pal_in.alpha_idx = a_aidx_ff;
      b_pal_in.color_idx = a_cidx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_en) begin
         b_pal_ff <= b_pal_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_pal   = b_pal_ff;

endmodule

>>> hw/rtl/dxt5_block_decoder.sv
// Top level of the DXT5 (BC3) block decoder: request capture, palette pipeline, texel emitter.
`timescale 1ns / 1ps

// A request (one 16-byte block) is taken at a clock edge where start is high
// and busy is low. The block comes out as sixteen texels in row-major order, back
// to back, each marked by rsp_valid for one cycle, with last set on texel 15. A
// block passes through the input register, the two palette stages and the texel
// emitter, whose texels go to the response register. The receiver cannot stall,
// so the texel emitter sets the sustained rate. Up to three more blocks wait in
// the input register and the two palette stages while the emitter runs; busy rises
// once they are full. csr_wdata selects RGB565 expansion (1: replicate high bits,
// 0: zero fill) and resets to 1; write it only while the decoder is idle.

module dxt5_block_decoder
   import dxt5_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    csr_we,
   input  logic    csr_wdata,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   // Configuration register
   logic expand_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         expand_ff <= 1'b1;
      end else if (csr_we) begin
         expand_ff <= csr_wdata;
      end
   end

   // Request capture stage
   logic    s1_valid_ff;
   req_type s1_req_ff;
   logic    s1_en;
   logic    pal_in_ready;

   assign s1_en = !s1_valid_ff || pal_in_ready;
   assign busy  = !s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_req_ff <= req_data;
      end
   end

   // Palette pipeline
   logic    pal_valid;
   logic    pal_ready;
   pal_type pal;

   dxt5_palette u_palette (
      .clock            (clock),
      .reset            (reset),
      .expand_replicate (expand_ff),
      .in_valid         (s1_valid_ff),
      .in_req           (s1_req_ff),
      .in_ready         (pal_in_ready),
      .out_valid        (pal_valid),
      .out_ready        (pal_ready),
      .out_pal          (pal)
   );

   // Texel emitter: holds one palette, shifts indices out one texel a cycle
   logic       em_active_ff;
   logic [3:0] em_count_ff;
   pal_type    em_pal_ff;
   logic       em_done;
   logic       em_load;

   assign em_done   = em_active_ff && (em_count_ff == TEXEL_LAST);
   assign pal_ready = !em_active_ff || em_done;
   assign em_load   = pal_valid && pal_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         em_active_ff <= 1'b0;
         em_count_ff  <= '0;
      end else if (em_load) begin
         em_active_ff <= 1'b1;
         em_count_ff  <= '0;
      end else if (em_active_ff) begin
         em_active_ff <= !em_done;
         em_count_ff  <= em_count_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (em_load) begin
         em_pal_ff <= pal;
      end else if (em_active_ff) begin
         em_pal_ff.alpha_idx <= {3'b000, em_pal_ff.alpha_idx[47:3]};
         em_pal_ff.color_idx <= {2'b00, em_pal_ff.color_idx[31:2]};
      end
   end

   // Palette lookup into the response register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic [2:0] a_sel;
   logic [1:0] c_sel;

   always_comb begin
      a_sel              = em_pal_ff.alpha_idx[2:0];
      c_sel              = em_pal_ff.color_idx[1:0];
      rsp_in.texel_index = em_count_ff;
      rsp_in.red         = em_pal_ff.color_tab[c_sel][0];
      rsp_in.green       = em_pal_ff.color_tab[c_sel][1];
      rsp_in.blue        = em_pal_ff.color_tab[c_sel][2];
      rsp_in.alpha_value = em_pal_ff.alpha_tab[a_sel];
      rsp_in.last        = em_count_ff == TEXEL_LAST;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= em_active_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Texels of one block come out back to back and in order
   a_texel_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=>
         rsp_valid && (rsp_data.texel_index == $past(rsp_data.texel_index) + 4'd1))
      else $error("texel sequence broken within a block");

   // A block's emission starts at texel zero
   a_emit_start: assert property (@(posedge clock) disable iff (reset)
      $rose(em_active_ff) |-> em_count_ff == '0)
      else $error("emitter started mid-block");

   // Last flag marks exactly texel 15
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (rsp_data.texel_index == TEXEL_LAST)))
      else $error("last flag out of step with texel index");

   // A new palette is only loaded when the emitter is free or finishing
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      em_active_ff && !em_done |=> !$past(em_load))
      else $error("palette loaded over an active block");

endmodule
